// File: src/biss_c_frame_decoder_core_macros.svh
// Assertion macros shared by the frame decoder RTL.
// Needs nothing else; include with the bare file name.
`ifndef BISS_C_FRAME_DECODER_CORE_MACROS_SVH
`define BISS_C_FRAME_DECODER_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define BISSC_ASSERT(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define BISSC_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// File: src/bissc_pkg.sv
// Constants, types and the CRC6 helper of the BiSS-C frame decoder.
// Has no dependencies; the interfaces, modules and testbench refer to it by scoped names.
package bissc_pkg;

	localparam int DEF_POSITION_BITS = 17;
	localparam int DEF_ACK_BITS      = 13;
	localparam int DEF_WINDOW_BITS   = 48;

	localparam int CRC_W    = 6;
	localparam int START_W  = 6;
	localparam int STATUS_W = 2;

	localparam logic [CRC_W-1:0] CRC_POLY_LOW = 6'h03;
	localparam logic [CRC_W-1:0] CRC_MASK     = 6'h3F;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SYNC_ERR = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ENC_ERR  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_CRC_ERR  = 2'd3;

	typedef struct packed {
		logic               found;
		logic [START_W-1:0] start;
	} sync_t;

	// Remainder left by a single one bit followed by bit_pos zero bits.
	// The CRC starts at zero, so the full remainder is the XOR of these columns.
	function automatic logic [CRC_W-1:0] crc6_column(input int bit_pos);
		logic [CRC_W-1:0] rem;
		logic             fb;
		rem = CRC_POLY_LOW;
		for (int k = 0; k < bit_pos; k++) begin
			fb  = rem[CRC_W-1];
			rem = {rem[CRC_W-2:0], 1'b0} & CRC_MASK;
			if (fb) begin
				rem = rem ^ CRC_POLY_LOW;
			end
		end
		return rem;
	endfunction

endpackage

// File: src/bissc_frame_if.sv
// Input channel of the frame decoder: one sampled line window per item.
// Depends on bissc_pkg for the default window width.
interface bissc_frame_if #(
	parameter int WINDOW_BITS = bissc_pkg::DEF_WINDOW_BITS
) ();
	logic                   valid;
	logic                   ready;
	logic [WINDOW_BITS-1:0] raw_frame;

	modport source (output valid, output raw_frame, input ready);
	modport sink (input valid, input raw_frame, output ready);
endinterface

// File: src/bissc_result_if.sv
// Output channel of the frame decoder: one decoded response per item.
// Depends on bissc_pkg for field widths and the default position width.
interface bissc_result_if #(
	parameter int POSITION_BITS = bissc_pkg::DEF_POSITION_BITS
) ();
	logic                                valid;
	logic                                ready;
	logic [bissc_pkg::STATUS_W-1:0]      status;
	logic [POSITION_BITS-1:0]            position;
	logic                                no_err;
	logic                                no_warn;
	logic [bissc_pkg::CRC_W-1:0]         crc_rx;
	logic [bissc_pkg::CRC_W-1:0]         crc_chk;
	logic [bissc_pkg::START_W-1:0]       payload_start;

	modport source (output valid, output status, output position, output no_err,
		output no_warn, output crc_rx, output crc_chk,
		output payload_start, input ready);
	modport sink (input valid, input status, input position, input no_err,
		input no_warn, input crc_rx, input crc_chk,
		input payload_start, output ready);
endinterface

// File: src/bissc_sync.sv
// Start-of-response search: tests every candidate offset in parallel and
// picks the earliest match. Depends on bissc_pkg.
module bissc_sync #(
	parameter int POSITION_BITS = bissc_pkg::DEF_POSITION_BITS,
	parameter int ACK_BITS      = bissc_pkg::DEF_ACK_BITS,
	parameter int WINDOW_BITS   = bissc_pkg::DEF_WINDOW_BITS
) (
	input  logic [WINDOW_BITS-1:0]                       win,
	output bissc_pkg::sync_t                             sync,
	output logic [POSITION_BITS+2+bissc_pkg::CRC_W-1:0]  fields
);
	localparam int FIELD_BITS = POSITION_BITS + 2 + bissc_pkg::CRC_W;
	localparam int RESP_LEN   = ACK_BITS + 2 + FIELD_BITS;
	localparam int LAST       = WINDOW_BITS - RESP_LEN;
	localparam int NUM_OFF    = (LAST >= 0) ? LAST + 1 : 0;

	generate
		if (NUM_OFF > 0) begin : g_search
			logic [NUM_OFF-1:0]    hit;
			logic [FIELD_BITS-1:0] cand [NUM_OFF];

			for (genvar s = 0; s < NUM_OFF; s++) begin : g_off
				logic lead_ok;
				if (s == 0) begin : g_first
					assign lead_ok = 1'b1;
				end else begin : g_rest
					// The bit just before the acknowledge run must be high.
					assign lead_ok = win[WINDOW_BITS-s];
				end
				assign hit[s] = lead_ok & ~(|win[WINDOW_BITS-1-s -: ACK_BITS])
					& win[WINDOW_BITS-1-s-ACK_BITS];
				assign cand[s] = win[WINDOW_BITS-3-s-ACK_BITS -: FIELD_BITS];
			end

			// Walk from the last offset down so the earliest match wins.
			always_comb begin
				sync.found = 1'b0;
				sync.start = '0;
				fields     = '0;
				for (int i = NUM_OFF - 1; i >= 0; i--) begin
					if (hit[i]) begin
						sync.found = 1'b1;
						sync.start = bissc_pkg::START_W'(i + ACK_BITS + 2);
						fields     = cand[i];
					end
				end
			end
		end else begin : g_none
			// The response cannot fit in the window, so no offset is ever tried.
			always_comb begin
				sync.found = 1'b0;
				sync.start = '0;
				fields     = win[FIELD_BITS-1:0] & '0;
			end
		end
	endgenerate
endmodule

// File: src/bissc_crc6.sv
// Inverted CRC6 (x^6+x+1, zero start) over position, error and warning bits,
// built as an XOR of constant columns. Depends on bissc_pkg.
module bissc_crc6 #(
	parameter int POSITION_BITS = bissc_pkg::DEF_POSITION_BITS
) (
	input  logic [POSITION_BITS+1:0]      data,
	output logic [bissc_pkg::CRC_W-1:0]   crc
);
	localparam int DATA_BITS = POSITION_BITS + 2;

	logic [bissc_pkg::CRC_W-1:0] col [DATA_BITS];
	logic [bissc_pkg::CRC_W-1:0] rem;

	for (genvar k = 0; k < DATA_BITS; k++) begin : g_col
		assign col[k] = bissc_pkg::crc6_column(k);
	end

	always_comb begin
		rem = '0;
		for (int k = 0; k < DATA_BITS; k++) begin
			if (data[k]) begin
				rem = rem ^ col[k];
			end
		end
		crc = ~rem;
	end
endmodule

// File: src/biss_c_frame_decoder_core.sv
// Top level of the BiSS-C response frame decoder.
// Depends on bissc_pkg, bissc_frame_if, bissc_result_if, bissc_sync, bissc_crc6
// and the assertion macros header.
//
//   channel   direction   payload
//   frame     in          raw_frame
//   result    out         status, position, no_err, no_warn,
//                         crc_rx, crc_chk, payload_start
//
// Every item passes through the input register and then the result register,
// with the offset search and CRC in between.
// One item is taken per cycle as long as the result side takes one per cycle.
// When the result side stalls, the input register holds a second item before
// frame.ready falls. Reset clears both valid flags and nothing else.
module biss_c_frame_decoder_core #(
	parameter int POSITION_BITS = bissc_pkg::DEF_POSITION_BITS,
	parameter int ACK_BITS      = bissc_pkg::DEF_ACK_BITS,
	parameter int WINDOW_BITS   = bissc_pkg::DEF_WINDOW_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	bissc_frame_if.sink     frame,
	bissc_result_if.source  result
);
	`include "biss_c_frame_decoder_core_macros.svh"

	localparam int FIELD_BITS = POSITION_BITS + 2 + bissc_pkg::CRC_W;
	localparam int CW         = bissc_pkg::CRC_W;

	logic                   v_s1;
	logic [WINDOW_BITS-1:0] raw_s1;
	logic                   v_s2;
	logic                   stall_s2;

	bissc_pkg::sync_t        sync;
	logic [FIELD_BITS-1:0]   fields;
	logic [POSITION_BITS-1:0] pos;
	logic                    err;
	logic                    warn;
	logic [CW-1:0]           rcrc;
	logic [CW-1:0]           ccrc;
	logic [bissc_pkg::STATUS_W-1:0] status_d;

	logic [bissc_pkg::STATUS_W-1:0] status_s2;
	logic [POSITION_BITS-1:0]       position_s2;
	logic                           no_err_s2;
	logic                           no_warn_s2;
	logic [CW-1:0]                  crc_rx_s2;
	logic [CW-1:0]                  crc_chk_s2;
	logic [bissc_pkg::START_W-1:0]  payload_start_s2;

	assign stall_s2    = v_s2 & ~result.ready;
	assign frame.ready = ~v_s1 | ~stall_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (frame.ready) begin
				v_s1 <= frame.valid;
			end
			if (!stall_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			raw_s1 <= frame.raw_frame;
		end
	end

	bissc_sync #(
		.POSITION_BITS (POSITION_BITS),
		.ACK_BITS      (ACK_BITS),
		.WINDOW_BITS   (WINDOW_BITS)
	) u_sync (
		.win    (raw_s1),
		.sync   (sync),
		.fields (fields)
	);

	assign pos  = fields[FIELD_BITS-1 -: POSITION_BITS];
	assign err  = fields[CW+1];
	assign warn = fields[CW];
	assign rcrc = fields[CW-1:0];

	bissc_crc6 #(
		.POSITION_BITS (POSITION_BITS)
	) u_crc (
		.data (fields[FIELD_BITS-1:CW]),
		.crc  (ccrc)
	);

	// Encoder error takes precedence over a CRC mismatch.
	always_comb begin
		if (!sync.found) begin
			status_d = bissc_pkg::STATUS_SYNC_ERR;
		end else if (!err) begin
			status_d = bissc_pkg::STATUS_ENC_ERR;
		end else if (rcrc != ccrc) begin
			status_d = bissc_pkg::STATUS_CRC_ERR;
		end else begin
			status_d = bissc_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && !stall_s2) begin
			status_s2        <= status_d;
			position_s2      <= (status_d == bissc_pkg::STATUS_OK) ? pos : '0;
			no_err_s2        <= sync.found & err;
			no_warn_s2       <= sync.found & warn;
			crc_rx_s2        <= sync.found ? rcrc : '0;
			crc_chk_s2       <= sync.found ? ccrc : '0;
			payload_start_s2 <= sync.start;
		end
	end

	assign result.valid         = v_s2;
	assign result.status        = status_s2;
	assign result.position      = position_s2;
	assign result.no_err        = no_err_s2;
	assign result.no_warn       = no_warn_s2;
	assign result.crc_rx        = crc_rx_s2;
	assign result.crc_chk       = crc_chk_s2;
	assign result.payload_start = payload_start_s2;

	`BISSC_ASSERT(a_sync_err_clears, clk, arst_n, v_s2 && status_s2 == bissc_pkg::STATUS_SYNC_ERR |-> payload_start_s2 == '0 && crc_chk_s2 == '0 && !no_err_s2, "sync error result carries nonzero fields")
	`BISSC_ASSERT(a_position_only_ok, clk, arst_n, v_s2 && position_s2 != '0 |-> status_s2 == bissc_pkg::STATUS_OK, "position reported on a failed frame")
	`BISSC_ASSERT(a_s1_kept_on_stall, clk, arst_n, v_s1 && stall_s2 |=> v_s1 && $stable(raw_s1), "input stage lost its item while the result stage was blocked")
	`BISSC_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !v_s1 && !v_s2, "pipeline not empty during reset")
endmodule

// File: tb/tb_top.sv
// Self-checking testbench of the BiSS-C response frame decoder core.
// Sends sampled line windows through bissc_frame_if, predicts each decoded response,
// and checks it on bissc_result_if. Depends on bissc_pkg, both interfaces and the core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = bissc_pkg::DEF_WINDOW_BITS;
	localparam int P = bissc_pkg::DEF_POSITION_BITS;
	localparam int ACK = bissc_pkg::DEF_ACK_BITS;
	localparam int CW = bissc_pkg::CRC_W;
	localparam int LAST_OFFSET = W - (ACK + 2 + P + 2 + CW);
	localparam int RANDOM_ITEMS = 1300;
	localparam int HOLD_CYCLES = 250;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [bissc_pkg::STATUS_W-1:0] status;
		logic [P-1:0]                   position;
		logic                           no_err;
		logic                           no_warn;
		logic [CW-1:0]                  crc_rx;
		logic [CW-1:0]                  crc_chk;
		logic [bissc_pkg::START_W-1:0]  payload_start;
	} decode_t;

	logic clk;
	logic arst_n;

	bissc_frame_if #(.WINDOW_BITS(W)) frame_ch ();
	bissc_result_if #(.POSITION_BITS(P)) result_ch ();

	biss_c_frame_decoder_core #(
		.POSITION_BITS(P),
		.ACK_BITS(ACK),
		.WINDOW_BITS(W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame_ch),
		.result(result_ch)
	);

	logic [W-1:0] frame_queue[$];
	decode_t      expected_results[$];
	bit           frame_taken;
	int           frames_sent;
	int           results_seen;
	int           error_count;
	int           hold_left;
	bit           hold_done;
	int           cycle_count;
	int           status_count[4];
	bit [LAST_OFFSET:0] offsets_seen;

	// Bit index 0 is the first received bit, which sits in the top bit of the window.
	function automatic logic line_bit(input logic [W-1:0] w, input int idx);
		return (idx >= 0 && idx < W) ? w[W-1-idx] : 1'b0;
	endfunction

	function automatic logic [CW-1:0] crc6_inv(input logic [P+1:0] data);
		logic [CW-1:0] rem;
		logic          fb;
		rem = '0;
		for (int k = P + 1; k >= 0; k--) begin
			fb  = rem[CW-1] ^ data[k];
			rem = {rem[CW-2:0], 1'b0};
			if (fb) begin
				rem = rem ^ bissc_pkg::CRC_POLY_LOW;
			end
		end
		return ~rem;
	endfunction

	function automatic decode_t decode_frame(input logic [W-1:0] w);
		decode_t      r;
		int           pstart;
		logic         ok;
		logic [P+1:0] payload;
		r = '0;
		pstart = -1;
		for (int s = 0; s <= LAST_OFFSET && pstart < 0; s++) begin
			if (s > 0 && !line_bit(w, s - 1)) begin
				continue;
			end
			ok = 1'b1;
			for (int k = 0; k < ACK; k++) begin
				ok = ok & ~line_bit(w, s + k);
			end
			if (ok && line_bit(w, s + ACK)) begin
				pstart = s + ACK + 2;
			end
		end
		if (pstart < 0) begin
			r.status = bissc_pkg::STATUS_SYNC_ERR;
			return r;
		end
		for (int k = 0; k < P + 2; k++) begin
			payload[P+1-k] = line_bit(w, pstart + k);
		end
		for (int k = 0; k < CW; k++) begin
			r.crc_rx[CW-1-k] = line_bit(w, pstart + P + 2 + k);
		end
		r.no_err        = payload[1];
		r.no_warn       = payload[0];
		r.crc_chk       = crc6_inv(payload);
		r.payload_start = pstart[bissc_pkg::START_W-1:0];
		if (!r.no_err) begin
			r.status = bissc_pkg::STATUS_ENC_ERR;
		end else if (r.crc_rx != r.crc_chk) begin
			r.status = bissc_pkg::STATUS_CRC_ERR;
		end else begin
			r.status   = bissc_pkg::STATUS_OK;
			r.position = payload[P+1:2];
		end
		return r;
	endfunction

	// Lays a response at the given offset over a background fill. The CRC is
	// correct unless crc_flip is nonzero.
	function automatic logic [W-1:0] make_frame(input int off, input logic [P-1:0] pos,
			input logic err, input logic warn, input logic [CW-1:0] crc_flip,
			input logic [W-1:0] fill);
		logic [W-1:0]  w;
		logic [P+1:0]  payload;
		logic [CW-1:0] crc;
		int            base;
		w = fill;
		if (off > 0) begin
			w[W-off] = 1'b1;
		end
		for (int k = 0; k < ACK; k++) begin
			w[W-1-(off+k)] = 1'b0;
		end
		w[W-1-(off+ACK)] = 1'b1;
		base = off + ACK + 2;
		payload = {pos, err, warn};
		crc = crc6_inv(payload) ^ crc_flip;
		for (int k = 0; k < P + 2; k++) begin
			w[W-1-(base+k)] = payload[P+1-k];
		end
		for (int k = 0; k < CW; k++) begin
			w[W-1-(base+P+2+k)] = crc[CW-1-k];
		end
		return w;
	endfunction

	function automatic logic [W-1:0] random_window();
		return W'({$urandom, $urandom});
	endfunction

	// Mostly well-formed responses with random content, then broken ones and line noise.
	function automatic logic [W-1:0] random_item();
		int            kind;
		logic [P-1:0]  pos;
		logic [CW-1:0] flip;
		logic [W-1:0]  w;
		kind = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: pos = '0;
			1: pos = '1;
			default: pos = P'($urandom_range(0, (1 << P) - 1));
		endcase
		flip = ($urandom_range(0, 99) < 70) ? '0 : CW'($urandom_range(1, (1 << CW) - 1));
		w = make_frame($urandom_range(0, LAST_OFFSET), pos, $urandom_range(0, 99) < 85,
			1'($urandom_range(0, 1)), flip, random_window());
		if (kind < 65) begin
			return w;
		end else if (kind < 82) begin
			w[$urandom_range(0, W - 1)] ^= 1'b1;
			return w;
		end
		return random_window();
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		error_count++;
		// The count keeps going after the first few lines so the log stays short.
		if (error_count <= 40) begin
			$display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
				$realtime, results_seen, what, got, want);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, expected_results.size());
			$display("** biss_c_frame_decoder_core: FAILED **");
			$finish;
		end
	end

	// Driver: holds an offered item until it is taken, otherwise offers or idles.
	always @(negedge clk) begin
		if (!arst_n) begin
			frame_ch.valid <= 1'b0;
		end else if (!frame_ch.valid || frame_taken) begin
			if (frame_queue.size() != 0 &&
					((frames_sent >= 700 && frames_sent < 900) ||
					$urandom_range(0, 99) >= 38)) begin
				frame_ch.valid     <= 1'b1;
				frame_ch.raw_frame <= frame_queue.pop_front();
				frames_sent++;
			end else begin
				frame_ch.valid <= 1'b0;
			end
		end
	end

	// Result side: random stalls, one long hold so the core backs up, and a steady stretch.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left       <= hold_left - 1;
		end else if (!hold_done && results_seen >= 300) begin
			hold_done       <= 1'b1;
			hold_left       <= HOLD_CYCLES;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= (results_seen >= 700 && results_seen < 900) ||
				$urandom_range(0, 99) >= 38;
		end
	end

	// Monitor: checks each result against the oldest prediction, then records new items.
	always @(posedge clk) begin
		decode_t want;
		if (!arst_n) begin
			frame_taken = 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, status", result_ch.status, 0);
				end else begin
					want = expected_results.pop_front();
					if (result_ch.status !== want.status)
						report_mismatch("status", result_ch.status, want.status);
					if (result_ch.position !== want.position)
						report_mismatch("position", result_ch.position, want.position);
					if (result_ch.no_err !== want.no_err)
						report_mismatch("no_err", result_ch.no_err, want.no_err);
					if (result_ch.no_warn !== want.no_warn)
						report_mismatch("no_warn", result_ch.no_warn, want.no_warn);
					if (result_ch.crc_rx !== want.crc_rx)
						report_mismatch("crc_rx", result_ch.crc_rx, want.crc_rx);
					if (result_ch.crc_chk !== want.crc_chk)
						report_mismatch("crc_chk", result_ch.crc_chk, want.crc_chk);
					if (result_ch.payload_start !== want.payload_start)
						report_mismatch("payload_start", result_ch.payload_start,
							want.payload_start);
					status_count[want.status]++;
					if (want.status != bissc_pkg::STATUS_SYNC_ERR)
						offsets_seen[want.payload_start - ACK - 2] = 1'b1;
				end
				results_seen++;
			end
			frame_taken = frame_ch.valid && frame_ch.ready;
			if (frame_taken) begin
				expected_results.push_back(decode_frame(frame_ch.raw_frame));
			end
		end
	end

	initial begin
		logic [W-1:0] w;
		arst_n             = 1'b0;
		frame_ch.valid     = 1'b0;
		frame_ch.raw_frame = '0;
		result_ch.ready    = 1'b0;

		// Directed items: empty and saturated lines, both ends of the offset range,
		// position extremes, encoder error, warning, bad CRC and damaged preambles.
		frame_queue.push_back('0);
		frame_queue.push_back('1);
		frame_queue.push_back(make_frame(0, '0, 1'b1, 1'b1, '0, '0));
		frame_queue.push_back(make_frame(0, '1, 1'b1, 1'b1, '0, '1));
		frame_queue.push_back(make_frame(LAST_OFFSET, '1, 1'b1, 1'b1, '0, '0));
		frame_queue.push_back(make_frame(LAST_OFFSET, '0, 1'b1, 1'b0, '0, '1));
		frame_queue.push_back(make_frame(1, 17'h15555, 1'b1, 1'b1, '0, '1));
		frame_queue.push_back(make_frame(4, 17'h0abcd, 1'b0, 1'b1, '0, '0));
		frame_queue.push_back(make_frame(4, 17'h1f00f, 1'b0, 1'b0, 6'h21, '1));
		frame_queue.push_back(make_frame(2, 17'h12345, 1'b1, 1'b0, '0, '0));
		frame_queue.push_back(make_frame(3, 17'h0f0f0, 1'b1, 1'b1, 6'h01, '0));
		frame_queue.push_back(make_frame(6, 17'h00001, 1'b1, 1'b1, '1, '1));
		// Preceding bit low, so the offset must be rejected.
		w = make_frame(5, 17'h1aaaa, 1'b1, 1'b1, '0, '0);
		w[W-5] = 1'b0;
		frame_queue.push_back(w);
		// A high bit inside the acknowledge run.
		w = make_frame(2, 17'h0cafe, 1'b1, 1'b1, '0, '0);
		w[W-1-8] = 1'b1;
		frame_queue.push_back(w);
		// Start bit missing.
		w = make_frame(7, 17'h10001, 1'b1, 1'b1, '0, '1);
		w[W-1-(7+ACK)] = 1'b0;
		frame_queue.push_back(w);
		// CDS bit set high; frames on a zero fill leave it low.
		w = make_frame(3, 17'h0ffff, 1'b1, 1'b1, '0, '0);
		w[W-1-(3+ACK+1)] = 1'b1;
		frame_queue.push_back(w);
		for (int i = 0; i <= LAST_OFFSET; i++) begin
			frame_queue.push_back(make_frame(i, P'($urandom_range(0, (1 << P) - 1)), 1'b1,
				1'($urandom_range(0, 1)), '0, random_window()));
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			frame_queue.push_back(random_item());
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (frame_queue.size() != 0 || frame_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Decoded %0d frames: %0d ok, %0d sync, %0d encoder and %0d CRC errors.",
			results_seen, status_count[bissc_pkg::STATUS_OK],
			status_count[bissc_pkg::STATUS_SYNC_ERR],
			status_count[bissc_pkg::STATUS_ENC_ERR],
			status_count[bissc_pkg::STATUS_CRC_ERR]);
		$display("Responses were found at %0d of %0d start offsets; %0d mismatches.",
			$countones(offsets_seen), LAST_OFFSET + 1, error_count);
		if (error_count == 0) begin
			$display("** biss_c_frame_decoder_core: PASSED **");
		end else begin
			$display("** biss_c_frame_decoder_core: FAILED **");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/bissc_pkg.sv
src/bissc_frame_if.sv
src/bissc_result_if.sv
src/bissc_sync.sv
src/bissc_crc6.sv
src/biss_c_frame_decoder_core.sv
tb/tb_top.sv
